[src/hcbp_pkg.sv]
package hcbp_pkg;

	localparam int BYTE_BITS = 8;
	localparam int CODE_W    = 32;
	localparam int LEN_W     = 6;
	localparam int PEND_W    = BYTE_BITS - 1;
	localparam int ACC_W     = CODE_W + PEND_W;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_ENCODE = 2'd1;
	localparam logic [1:0] ACT_FLUSH  = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [7:0]        symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} tbl_entry_t;

	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} qent_t;

	typedef struct packed {
		logic             busy;
		logic [LEN_W-1:0] tot;
	} bk_stat_t;

endpackage

[src/hcbp_front.sv]
module hcbp_front #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hcbp_pkg::in_word_t in_data,
	output logic              q_valid,
	input  logic              q_ready,
	output hcbp_pkg::qent_t   q_data
);
	import hcbp_pkg::*;

	localparam int SymW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LenCap = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	tbl_entry_t              tbl_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] loaded_q;

	logic              valid_s1;
	logic              flush_s1;
	logic              hit_s1;
	tbl_entry_t        rd_s1;

	logic              accept;
	logic              in_range;
	logic              wr_en;
	logic              queued;
	logic [SymW-1:0]   idx;
	logic [LEN_W-1:0]  cap_len;
	logic [CODE_W-1:0] mask;

	assign in_range = {1'b0, in_data.symbol} < 9'(SYMBOL_COUNT);
	assign idx      = in_data.symbol[SymW-1:0];
	assign cap_len  = (in_data.code_len > LEN_W'(LenCap)) ? LEN_W'(LenCap) : in_data.code_len;
	assign mask     = ~({CODE_W{1'b1}} << cap_len);
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && (in_data.action == ACT_LOAD) && in_range;
	assign queued   = ((in_data.action == ACT_ENCODE) && in_range) ||
	                  (in_data.action == ACT_FLUSH);

	assign in_ready = !valid_s1 || q_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[idx] <= '{code: in_data.code_bits & mask, len: cap_len};
		end
		if (accept) begin
			rd_s1    <= tbl_mem[idx];
			hit_s1   <= loaded_q[idx];
			flush_s1 <= (in_data.action == ACT_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				loaded_q[idx] <= 1'b1;
			end
			if (in_ready) begin
				valid_s1 <= accept && queued;
			end
		end
	end

	assign q_valid    = valid_s1;
	assign q_data.flush = flush_s1;
	assign q_data.code  = hit_s1 ? rd_s1.code : '0;
	assign q_data.len   = hit_s1 ? rd_s1.len : '0;

endmodule

[src/hcbp_queue.sv]
module hcbp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  hcbp_pkg::qent_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output hcbp_pkg::qent_t pop_data
);
	import hcbp_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	qent_t           slots_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CntW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/hcbp_back.sv]
module hcbp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  hcbp_pkg::qent_t     q_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hcbp_pkg::out_word_t out_data,
	output hcbp_pkg::bk_stat_t  stat
);
	import hcbp_pkg::*;

	logic             busy_q;
	logic [ACC_W-1:0] acc_q;
	logic [LEN_W-1:0] tot_q;
	logic [PEND_W-1:0] pend_q;
	logic [2:0]       pcnt_q;
	logic             ovalid_q;
	logic [7:0]       obyte_q;
	logic             olast_q;

	logic             out_free;
	logic             emit;
	logic [LEN_W-1:0] rem;
	logic             rem_last;
	logic             done_now;
	logic             item_done;
	logic             pop;
	logic [7:0]       byte_w;
	logic [2:0]       eff_cnt;
	logic [PEND_W-1:0] eff_pend;
	logic [7:0]       pad_byte;
	logic [ACC_W-1:0] new_acc;
	logic [LEN_W-1:0] new_tot;

	assign out_free  = !ovalid_q || out_ready;
	assign emit      = busy_q && out_free;
	assign rem       = tot_q - LEN_W'(BYTE_BITS);
	assign rem_last  = rem < LEN_W'(BYTE_BITS);
	assign byte_w    = 8'(acc_q >> rem);
	assign done_now  = emit && rem_last;
	assign item_done = !busy_q || done_now;
	assign q_ready   = item_done;
	assign pop       = q_valid && item_done;

	// leftover bits as seen by the next word, including a remainder finishing now
	assign eff_cnt  = busy_q ? rem[2:0] : pcnt_q;
	assign eff_pend = busy_q ? (acc_q[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem[2:0])) : pend_q;
	assign pad_byte = 8'({1'b0, eff_pend} << (4'(BYTE_BITS) - {1'b0, eff_cnt}));

	always_comb begin
		if (q_data.flush) begin
			new_acc = ACC_W'(pad_byte);
			new_tot = (eff_cnt != '0) ? LEN_W'(BYTE_BITS) : '0;
		end else begin
			new_acc = (ACC_W'(eff_pend) << q_data.len) | ACC_W'(q_data.code);
			new_tot = LEN_W'(eff_cnt) + q_data.len;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= new_acc;
			tot_q <= new_tot;
		end else if (emit) begin
			tot_q <= rem;
		end
		if (emit) begin
			obyte_q <= byte_w;
			olast_q <= rem_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pend_q   <= '0;
			pcnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= new_tot >= LEN_W'(BYTE_BITS);
				if (new_tot < LEN_W'(BYTE_BITS)) begin
					pend_q <= new_acc[PEND_W-1:0];
					pcnt_q <= new_tot[2:0];
				end
			end else if (done_now) begin
				busy_q <= 1'b0;
				pend_q <= eff_pend;
				pcnt_q <= eff_cnt;
			end
			if (out_free) begin
				ovalid_q <= emit;
			end
		end
	end

	assign out_valid         = ovalid_q;
	assign out_data.out_byte = obyte_q;
	assign out_data.last     = olast_q;
	assign stat.busy         = busy_q;
	assign stat.tot          = tot_q;

endmodule

[src/huffman_code_bit_packer_unit.sv]
// channel  signals                     word        moves when
// in       in_valid/in_ready/in_data   in_word_t   in_valid && in_ready
// out      out_valid/out_ready/out_data out_word_t out_valid && out_ready
//
// Input takes one word per cycle while the queue has room; lookup is one registered
// table read, then a queue. The packer takes encodes and flushes one at a time and
// emits their bytes in turn; loads never reach the packer. The first byte of a word
// passes the lookup register, the queue, the packer accumulator and output register.
// Reset clears the table valid bits at once; no clearing pass is needed.
// A stalled output holds the packer; the queue lets input run on until it fills.
module huffman_code_bit_packer_unit #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 32,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hcbp_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hcbp_pkg::out_word_t out_data
);
	import hcbp_pkg::*;

	logic     fq_valid;
	logic     fq_ready;
	qent_t    fq_data;
	logic     qb_valid;
	logic     qb_ready;
	qent_t    qb_data;
	bk_stat_t bk_stat;

	hcbp_front #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	hcbp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_data)
	);

	hcbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (qb_valid),
		.q_ready  (qb_ready),
		.q_data   (qb_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.stat     (bk_stat)
	);

	a_busy_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.busy |-> (bk_stat.tot >= LEN_W'(BYTE_BITS)))
		else $error("packer busy without a full byte");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> bk_stat.busy)
		else $error("non-final byte shown with packer idle");

	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(!bk_stat.busy && (!out_valid || out_ready)) |=> !out_valid)
		else $error("byte emitted while packer idle");

endmodule

[sim/tb_huffman_code_bit_packer_unit.sv]
module tb_huffman_code_bit_packer_unit;
	import hcbp_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_CYCLES = 16;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		bit       drain;
		in_word_t w;
	} stim_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	huffman_code_bit_packer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// code table and bit buffer as the block should hold them
	logic [CODE_W-1:0] tbl_code [256];
	logic [LEN_W-1:0]  tbl_len  [256];
	logic [6:0]        buf_bits;
	int                buf_cnt;

	stim_t     stim_q[$];
	out_word_t expected_bytes[$];
	int        loaded_syms[$];

	int  err_cnt;
	int  n_words_in;
	int  n_loads;
	int  n_encodes;
	int  n_flushes;
	int  n_bytes;
	int  idle_cycles;
	int  in_gap;
	int  out_stall;
	int  out_wait;
	bit  in_burst;
	bit  out_burst;

	function automatic int next_wait(inout bit burst);
		if ($urandom_range(0, 19) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic pack_word(input in_word_t w);
		int        len;
		int        total;
		logic [63:0] acc;
		logic [63:0] shifted;
		out_word_t o;
		case (w.action)
			ACT_LOAD: begin
				len = (w.code_len > CODE_W) ? CODE_W : int'(w.code_len);
				tbl_len[w.symbol] = LEN_W'(len);
				tbl_code[w.symbol] = CODE_W'(w.code_bits & ((64'd1 << len) - 64'd1));
				n_loads++;
			end
			ACT_ENCODE: begin
				len = int'(tbl_len[w.symbol]);
				acc = ({57'd0, buf_bits} << len) | {32'd0, tbl_code[w.symbol]};
				total = buf_cnt + len;
				while (total >= BYTE_BITS) begin
					total -= BYTE_BITS;
					shifted = acc >> total;
					o.out_byte = shifted[7:0];
					o.last = (total < BYTE_BITS);
					expected_bytes.push_back(o);
				end
				buf_cnt = total;
				shifted = acc & ((64'd1 << total) - 64'd1);
				buf_bits = shifted[6:0];
				n_encodes++;
			end
			ACT_FLUSH: begin
				if (buf_cnt != 0) begin
					shifted = {57'd0, buf_bits} << (BYTE_BITS - buf_cnt);
					o.out_byte = shifted[7:0];
					o.last = 1'b1;
					expected_bytes.push_back(o);
				end
				buf_cnt = 0;
				buf_bits = '0;
				n_flushes++;
			end
			default: ;
		endcase
	endtask

	task automatic add_word(input logic [1:0] act, input logic [7:0] sym,
			input logic [31:0] code, input logic [5:0] len);
		stim_t s;
		s.drain = 1'b0;
		s.w.action = act;
		s.w.symbol = sym;
		s.w.code_bits = code;
		s.w.code_len = len;
		stim_q.push_back(s);
		if (act == ACT_LOAD && len != 0)
			loaded_syms.push_back(int'(sym));
	endtask

	task automatic add_drain();
		stim_t s;
		s = '0;
		s.drain = 1'b1;
		stim_q.push_back(s);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver and predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				pack_word(in_data);
				n_words_in++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (stim_q.size() != 0 && stim_q[0].drain) begin
					in_valid <= 1'b0;
					if (expected_bytes.size() == 0)
						void'(stim_q.pop_front());
				end else if (stim_q.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= stim_q[0].w;
					void'(stim_q.pop_front());
					in_gap <= next_wait(in_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else if (out_valid && out_ready) begin
			n_bytes++;
			if (expected_bytes.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected word byte=%02h last=%0b", $time,
					out_data.out_byte, out_data.last);
			end else begin
				if (out_data.out_byte !== expected_bytes[0].out_byte) begin
					err_cnt++;
					$display("%0t: out_byte expected %02h actual %02h", $time,
						expected_bytes[0].out_byte, out_data.out_byte);
				end
				if (out_data.last !== expected_bytes[0].last) begin
					err_cnt++;
					$display("%0t: last expected %0b actual %0b", $time,
						expected_bytes[0].last, out_data.last);
				end
				void'(expected_bytes.pop_front());
			end
			out_wait = next_wait(out_burst);
			if (out_wait == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				out_stall <= out_wait;
			end
		end else if (!out_ready) begin
			if (out_stall <= 1) begin
				out_ready <= 1'b1;
				out_stall <= 0;
			end else begin
				out_stall <= out_stall - 1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int sym;
		int len;
		for (int i = 0; i < 256; i++) begin
			tbl_code[i] = '0;
			tbl_len[i] = '0;
		end
		buf_bits = '0;
		buf_cnt = 0;
		err_cnt = 0;
		n_words_in = 0;
		n_loads = 0;
		n_encodes = 0;
		n_flushes = 0;
		n_bytes = 0;
		idle_cycles = 0;
		in_burst = 1'b0;
		out_burst = 1'b0;
		arst_n = 1'b0;

		// directed: unloaded symbol, empty flush, saturation, dropped high bits
		add_word(ACT_ENCODE, 8'd5, 32'hFFFF_FFFF, 6'd63);
		add_word(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		add_word(ACT_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd63);
		add_word(ACT_LOAD, 8'd255, 32'h8000_0001, 6'd1);
		add_word(ACT_LOAD, 8'd1, 32'h0000_0000, 6'd32);
		add_word(ACT_LOAD, 8'd2, 32'hFFFF_FFFD, 6'd3);
		add_word(ACT_LOAD, 8'd3, 32'hAAAA_AAAA, 6'd33);
		add_word(ACT_LOAD, 8'd4, 32'hDEAD_BEEF, 6'd0);
		add_word(ACT_NONE, 8'd255, 32'hFFFF_FFFF, 6'd63);
		add_word(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
		add_word(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
		add_word(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
		add_word(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
		add_word(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
		add_word(ACT_ENCODE, 8'd4, 32'h0, 6'd0);
		add_word(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		add_word(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		add_word(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
		add_word(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
		add_word(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
		add_word(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		add_word(ACT_LOAD, 8'd0, 32'h0000_003C, 6'd8);
		add_word(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
		add_word(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		add_drain();

		for (int i = 0; i < 220; i++) begin
			if (i == 110)
				add_drain();
			r = $urandom_range(0, 99);
			if (i < 24 || (r >= 63 && r < 75)) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(1, 10);
				else if (r < 85)
					len = $urandom_range(11, 32);
				else if (r < 95)
					len = $urandom_range(33, 63);
				else
					len = 0;
				add_word(ACT_LOAD, 8'($urandom_range(0, 255)), $urandom(), 6'(len));
			end else if (r < 55) begin
				sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				add_word(ACT_ENCODE, 8'(sym), $urandom(), 6'($urandom_range(0, 63)));
			end else if (r < 63) begin
				add_word(ACT_ENCODE, 8'($urandom_range(0, 255)), $urandom(),
					6'($urandom_range(0, 63)));
			end else if (r < 92) begin
				add_word(ACT_FLUSH, 8'($urandom_range(0, 255)), $urandom(),
					6'($urandom_range(0, 63)));
			end else begin
				add_word(ACT_NONE, 8'($urandom_range(0, 255)), $urandom(),
					6'($urandom_range(0, 63)));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d words in (%0d load, %0d encode, %0d flush), %0d bytes checked",
			n_words_in, n_loads, n_encodes, n_flushes, n_bytes);
		$display("run: random gaps and stalls on both channels, %0d mismatches", err_cnt);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
src/hcbp_pkg.sv
src/hcbp_front.sv
src/hcbp_queue.sv
src/hcbp_back.sv
src/huffman_code_bit_packer_unit.sv
sim/tb_huffman_code_bit_packer_unit.sv
